### rtl/trfw_pkg.sv
// ----------------------------------------------------------------------------
// Tile region distributor package
// Shared widths, register indexes, status codes and payload types.
// ----------------------------------------------------------------------------
package trfw_pkg;

    localparam int AXIS_BITS   = 16;
    localparam int OVL_BITS    = 12;
    localparam int MAX_WORKERS = 1024;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPEC_COUNT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_CHUNK     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_OVERLAP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEC_OFFSET    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_COUNT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_CHUNK   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_OVERLAP = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_OFFSET  = 4'd7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PAST  = 2'd1,
        ST_RANGE = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef struct packed {
        logic [10:0] worker_count;
        logic [9:0]  worker_index;
        logic [31:0] local_index;
    } in_t;

    typedef struct packed {
        logic [17:0] first_spec_pos;
        logic [17:0] good_spec_start;
        logic [16:0] spec_len;
        logic [15:0] good_spec_len;
        logic [17:0] first_lambda_pos;
        logic [17:0] good_lambda_start;
        logic [16:0] lambda_len;
        logic [15:0] good_lambda_len;
        logic [31:0] worker_tiles;
        status_t     status;
    } out_t;

    typedef struct packed {
        in_t     item;
        status_t err;
        logic [AXIS_BITS-1:0] ns;
    } share_side_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] wtiles;
    } tile_side_t;

endpackage

### rtl/trfw_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a valid bit and sideband data
// that travel alongside the operands.
// ----------------------------------------------------------------------------
module trfw_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] out_side
);

    genvar i;
    for (i = 0; i < NUM_W; i++) begin : g_step
        logic              v_in;
        logic [NUM_W-1:0]  q_in;
        logic [DEN_W-1:0]  r_in;
        logic [DEN_W-1:0]  d_in;
        logic [SIDE_W-1:0] s_in;
        logic [DEN_W:0]    shifted;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic              v_reg;
        logic [NUM_W-1:0]  q_reg;
        logic [DEN_W-1:0]  r_reg;
        logic [DEN_W-1:0]  d_reg;
        logic [SIDE_W-1:0] side_reg;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = g_step[i-1].v_reg;
            assign q_in = g_step[i-1].q_reg;
            assign r_in = g_step[i-1].r_reg;
            assign d_in = g_step[i-1].d_reg;
            assign s_in = g_step[i-1].side_reg;
        end

        assign shifted = {r_in, q_in[NUM_W-1]};
        assign ge      = shifted >= {1'b0, d_in};
        assign diff    = shifted - {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg    <= {q_in[NUM_W-2:0], ge};
                r_reg    <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                d_reg    <= d_in;
                side_reg <= s_in;
            end
        end
    end

    assign out_valid = g_step[NUM_W-1].v_reg;
    assign quo       = g_step[NUM_W-1].q_reg;
    assign rem       = g_step[NUM_W-1].r_reg;
    assign out_side  = g_step[NUM_W-1].side_reg;

endmodule

### rtl/tile_region_for_worker.sv
// ----------------------------------------------------------------------------
// Tile region distributor
// Answers one query per transaction: the region of one tile of one worker's
// run in a two-dimensional tiling with halo, plus that worker's tile count.
//
// Configuration is written through cfg_we, cfg_index and cfg_wdata while no
// transaction is in flight; writes to unknown indexes are ignored.
// Queries enter on the s_ valid/ready channel and results leave on the m_
// valid/ready channel, one result per query, in order.
// The path holds three chains of pipelined dividers (tiles per axis, tiles
// per worker, tile position on the axes), each one quotient bit per stage,
// so a new query can enter in every cycle while s_ready is high; a result
// shows on m_valid once its query has passed the entry stage and every chain.
// When the receiver stalls, a skid register catches the result in flight
// and the whole pipeline then holds; s_ready drops until the skid drains.
// Reset clears all valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module tile_region_for_worker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [trfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trfw_pkg::AXIS_BITS-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  trfw_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output trfw_pkg::out_t                   m_data
);
    import trfw_pkg::*;

    logic [AXIS_BITS-1:0] sn_reg, sc_reg, sf_reg, ln_reg, lc_reg, lf_reg;
    logic [OVL_BITS-1:0]  so_reg, lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sn_reg <= AXIS_BITS'(1);
            sc_reg <= AXIS_BITS'(1);
            so_reg <= '0;
            sf_reg <= '0;
            ln_reg <= AXIS_BITS'(1);
            lc_reg <= AXIS_BITS'(1);
            lo_reg <= '0;
            lf_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SPEC_COUNT:     sn_reg <= cfg_wdata;
                REG_SPEC_CHUNK:     sc_reg <= cfg_wdata;
                REG_SPEC_OVERLAP:   so_reg <= cfg_wdata[OVL_BITS-1:0];
                REG_SPEC_OFFSET:    sf_reg <= cfg_wdata;
                REG_LAMBDA_COUNT:   ln_reg <= cfg_wdata;
                REG_LAMBDA_CHUNK:   lc_reg <= cfg_wdata;
                REG_LAMBDA_OVERLAP: lo_reg <= cfg_wdata[OVL_BITS-1:0];
                REG_LAMBDA_OFFSET:  lf_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic sk_valid_reg;
    out_t sk_data_reg;
    logic m_valid_reg;
    out_t m_data_reg;

    assign en      = !sk_valid_reg;
    assign s_ready = en;

    // Entry stage: configuration and range checks.
    logic    a_valid_reg;
    in_t     a_item_reg;
    status_t a_err_reg;
    logic    bad_cfg, bad_range;

    assign bad_cfg = (sc_reg == '0) || (lc_reg == '0) || (sn_reg == '0) ||
                     (ln_reg == '0) || (sf_reg < {4'b0, so_reg}) ||
                     (lf_reg < {4'b0, lo_reg}) || (s_data.worker_count == '0) ||
                     (s_data.worker_count > 11'(MAX_WORKERS));
    assign bad_range = {1'b0, s_data.worker_index} >= s_data.worker_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= s_data;
            a_err_reg  <= bad_cfg ? ST_BAD : (bad_range ? ST_RANGE : ST_OK);
        end
    end

    // Tiles per axis.
    logic                 d1_valid, d2_valid;
    logic [AXIS_BITS-1:0] d1_q, d1_r, d2_q, d2_r;
    in_t                  d1_item;
    status_t              d2_err;

    trfw_div #(.NUM_W(AXIS_BITS), .DEN_W(AXIS_BITS), .SIDE_W($bits(in_t))) u_div_spec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_valid_reg),
        .num      (sn_reg),
        .den      (sc_reg),
        .in_side  (a_item_reg),
        .out_valid(d1_valid),
        .quo      (d1_q),
        .rem      (d1_r),
        .out_side (d1_item)
    );

    trfw_div #(.NUM_W(AXIS_BITS), .DEN_W(AXIS_BITS), .SIDE_W($bits(status_t))) u_div_lambda (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_valid_reg),
        .num      (ln_reg),
        .den      (lc_reg),
        .in_side  (a_err_reg),
        .out_valid(d2_valid),
        .quo      (d2_q),
        .rem      (d2_r),
        .out_side (d2_err)
    );

    logic                 b_valid_reg, c_valid_reg;
    in_t                  b_item_reg, c_item_reg;
    status_t              b_err_reg, c_err_reg;
    logic [AXIS_BITS-1:0] b_ns_reg, b_nl_reg, c_ns_reg;
    logic [31:0]          b_total;
    logic [31:0]          c_total_reg;

    assign b_total = 32'(b_ns_reg) * 32'(b_nl_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= d1_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_item_reg  <= d1_item;
            b_err_reg   <= d2_err;
            b_ns_reg    <= d1_q + AXIS_BITS'(d1_r != '0);
            b_nl_reg    <= d2_q + AXIS_BITS'(d2_r != '0);
            c_item_reg  <= b_item_reg;
            c_err_reg   <= b_err_reg;
            c_ns_reg    <= b_ns_reg;
            c_total_reg <= b_total;
        end
    end

    // Tiles per worker.
    logic        d3_valid;
    logic [31:0] d3_q;
    logic [10:0] d3_r;
    share_side_t c_side, d3_side;

    assign c_side = '{item: c_item_reg, err: c_err_reg, ns: c_ns_reg};

    trfw_div #(.NUM_W(32), .DEN_W(11), .SIDE_W($bits(share_side_t))) u_div_share (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (c_valid_reg),
        .num      (c_total_reg),
        .den      (c_item_reg.worker_count),
        .in_side  (c_side),
        .out_valid(d3_valid),
        .quo      (d3_q),
        .rem      (d3_r),
        .out_side (d3_side)
    );

    logic                 e_valid_reg, f_valid_reg, g_valid_reg;
    share_side_t          e_side_reg;
    logic [31:0]          e_base_reg, e_wtiles_reg;
    logic [9:0]           e_minw_reg;
    logic [31:0]          f_first_reg, f_wtiles_reg, f_lidx_reg;
    status_t              f_err_reg;
    logic [AXIS_BITS-1:0] f_ns_reg, g_ns_reg;
    logic [31:0]          g_abs_reg, g_wtiles_reg;
    status_t              g_status_reg;
    logic                 e_lower;
    logic [41:0]          e_prod;
    logic [31:0]          f_abs;

    assign e_lower = {1'b0, d3_side.item.worker_index} < d3_r;
    assign e_prod  = e_base_reg * e_side_reg.item.worker_index;
    assign f_abs   = f_first_reg + f_lidx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d3_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg   <= d3_side;
            e_base_reg   <= d3_q;
            e_wtiles_reg <= e_lower ? d3_q + 32'd1 : d3_q;
            e_minw_reg   <= e_lower ? d3_side.item.worker_index : d3_r[9:0];

            f_first_reg  <= e_prod[31:0] + {22'b0, e_minw_reg};
            f_wtiles_reg <= e_wtiles_reg;
            f_lidx_reg   <= e_side_reg.item.local_index;
            f_err_reg    <= e_side_reg.err;
            f_ns_reg     <= e_side_reg.ns;

            g_abs_reg    <= f_abs;
            g_wtiles_reg <= f_wtiles_reg;
            g_ns_reg     <= f_ns_reg;
            if (f_err_reg != ST_OK) begin
                g_status_reg <= f_err_reg;
            end else if (f_lidx_reg >= f_wtiles_reg) begin
                g_status_reg <= ST_PAST;
            end else begin
                g_status_reg <= ST_OK;
            end
        end
    end

    // Tile position on the two axes.
    logic                 d4_valid;
    logic [31:0]          d4_q;
    logic [AXIS_BITS-1:0] d4_r;
    tile_side_t           g_side, d4_side;

    assign g_side = '{status: g_status_reg, wtiles: g_wtiles_reg};

    trfw_div #(.NUM_W(32), .DEN_W(AXIS_BITS), .SIDE_W($bits(tile_side_t))) u_div_tile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (g_valid_reg),
        .num      (g_abs_reg),
        .den      (g_ns_reg),
        .in_side  (g_side),
        .out_valid(d4_valid),
        .quo      (d4_q),
        .rem      (d4_r),
        .out_side (d4_side)
    );

    logic                   h_valid_reg;
    tile_side_t             h_side_reg;
    logic [AXIS_BITS-1:0]   h_sbase_reg, h_lbase_reg;
    logic [2*AXIS_BITS-1:0] s_prod, l_prod;

    assign s_prod = d4_r * sc_reg;
    assign l_prod = d4_q[AXIS_BITS-1:0] * lc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= d4_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_side_reg  <= d4_side;
            h_sbase_reg <= s_prod[AXIS_BITS-1:0];
            h_lbase_reg <= l_prod[AXIS_BITS-1:0];
        end
    end

    // Region fields.
    logic [15:0] s_rest, l_rest, s_glen, l_glen;
    logic [17:0] s_fg, l_fg;
    out_t        out_next;

    assign s_rest = sn_reg - h_sbase_reg;
    assign l_rest = ln_reg - h_lbase_reg;
    assign s_glen = (s_rest < sc_reg) ? s_rest : sc_reg;
    assign l_glen = (l_rest < lc_reg) ? l_rest : lc_reg;
    assign s_fg   = {2'b0, h_sbase_reg} + {2'b0, sf_reg};
    assign l_fg   = {2'b0, h_lbase_reg} + {2'b0, lf_reg};

    always_comb begin
        out_next = '0;
        out_next.status = h_side_reg.status;
        if (h_side_reg.status == ST_OK || h_side_reg.status == ST_PAST) begin
            out_next.worker_tiles = h_side_reg.wtiles;
        end
        if (h_side_reg.status == ST_OK) begin
            out_next.good_spec_start   = s_fg;
            out_next.first_spec_pos    = s_fg - {6'b0, so_reg};
            out_next.good_spec_len     = s_glen;
            out_next.spec_len          = {1'b0, s_glen} + {4'b0, so_reg, 1'b0};
            out_next.good_lambda_start = l_fg;
            out_next.first_lambda_pos  = l_fg - {6'b0, lo_reg};
            out_next.good_lambda_len   = l_glen;
            out_next.lambda_len        = {1'b0, l_glen} + {4'b0, lo_reg, 1'b0};
        end
    end

    // Output register with skid stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            if (sk_valid_reg) begin
                m_valid_reg  <= 1'b1;
                m_data_reg   <= sk_data_reg;
                sk_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= h_valid_reg;
                m_data_reg  <= out_next;
            end
        end else if (h_valid_reg && en) begin
            sk_valid_reg <= 1'b1;
            sk_data_reg  <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg |-> m_valid_reg)
        else $error("skid register holds a transaction while the output is empty");

    a_axis_div_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        d1_valid == d2_valid)
        else $error("axis dividers out of step");

    a_err_no_tiles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == ST_BAD || m_data_reg.status == ST_RANGE))
        |-> (m_data_reg.worker_tiles == '0))
        else $error("worker tile count reported with a configuration or range error");

    a_err_no_region: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != ST_OK)
        |-> (m_data_reg.spec_len == '0 && m_data_reg.lambda_len == '0 &&
             m_data_reg.good_spec_start == '0 && m_data_reg.good_lambda_start == '0))
        else $error("region reported with an error status");

    a_ok_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == ST_OK)
        |-> (m_data_reg.good_spec_len != '0 && m_data_reg.good_lambda_len != '0 &&
             m_data_reg.worker_tiles != '0))
        else $error("good tile is empty on an axis");
`endif

endmodule
